// ----- rtl/core/bps_pkg.sv -----
// Shared constants and types for the bitonic peak search block.
package bps_pkg;

  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam int PROBE_LIMIT_DEF  = 2048;

  localparam int ELEM_W   = 32;
  localparam int INDEX_W  = 10;
  localparam int STATUS_W = 2;

  // Result codes
  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND = 2'd0,
    ST_SHORT = 2'd1,
    ST_RANGE = 2'd2,
    ST_LIMIT = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_LOAD,
    S_CHECK,
    S_RD_MID,
    S_RD_RGT,
    S_EVAL,
    S_EMIT
  } state_t;

endpackage

// ----- rtl/core/bps_store.sv -----
// Element store: one write port, one read port, registered read data.
module bps_store #(
  parameter int DEPTH = bps_pkg::MAX_ELEMENTS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [bps_pkg::ELEM_W-1:0] wr_data,
  input  logic [AW-1:0]             rd_addr,
  output logic [bps_pkg::ELEM_W-1:0] rd_data
);

  logic [bps_pkg::ELEM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/core/bps_ctrl.sv -----
// Load counter and probe sequencer for the peak search.
module bps_ctrl #(
  parameter int MAX_ELEMENTS = bps_pkg::MAX_ELEMENTS_DEF,
  parameter int PROBE_LIMIT  = bps_pkg::PROBE_LIMIT_DEF,
  parameter int AW           = $clog2(MAX_ELEMENTS)
) (
  input  logic                         clk,
  input  logic                         rst,
  // element transaction
  input  logic                         in_valid,
  input  logic                         in_last,
  output logic                         in_stall,
  // store ports
  output logic                         wr_en,
  output logic [AW-1:0]                wr_addr,
  output logic [AW-1:0]                rd_addr,
  input  logic [bps_pkg::ELEM_W-1:0]   rd_data,
  // result hand-off
  input  logic                         res_free,
  output logic                         res_load,
  output logic [bps_pkg::INDEX_W-1:0]  res_index,
  output bps_pkg::status_t             res_status
);

  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int PW = CW + 2;
  localparam int LW = $clog2(PROBE_LIMIT + 1);
  localparam int XW = (PW > bps_pkg::INDEX_W) ? PW : bps_pkg::INDEX_W;

  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_ELEMENTS);
  localparam logic [LW-1:0] LIMIT     = LW'(PROBE_LIMIT);

  bps_pkg::state_t state, state_next;

  logic [CW-1:0]              count;
  logic [CW-1:0]              n;
  logic signed [PW-1:0]       pos;
  logic [CW-1:0]              step;
  logic [LW-1:0]              probes;
  logic signed [bps_pkg::ELEM_W-1:0] lft;
  logic signed [bps_pkg::ELEM_W-1:0] mid;

  logic                       accept;
  logic                       not_full;
  logic [CW-1:0]              n_next;
  logic                       short_arr;
  logic                       at_limit;
  logic                       out_of_range;
  logic signed [PW-1:0]       n_s;
  logic signed [bps_pkg::ELEM_W-1:0] rgt;
  logic                       is_peak;
  logic                       go_right;
  logic [CW-1:0]              step_half;
  logic [CW-1:0]              step_next;
  logic [XW-1:0]              pos_wide;

  assign accept    = in_valid && !in_stall;
  assign not_full  = (count < COUNT_MAX);
  assign n_next    = count + CW'(not_full);
  assign short_arr = (n_next < CW'(3));

  assign n_s          = $signed(PW'(n));
  assign at_limit     = (probes >= LIMIT);
  assign out_of_range = (pos < PW'(1)) || (pos > n_s - PW'(2));

  assign rgt       = $signed(rd_data);
  assign is_peak   = (lft < mid) && (rgt < mid);
  assign go_right  = (mid < rgt);
  assign step_half = step >> 1;
  assign step_next = (step_half == '0) ? CW'(1) : step_half;
  assign pos_wide  = XW'($unsigned(pos));

  assign wr_en   = accept && not_full;
  assign wr_addr = count[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bps_pkg::S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    res_load   = 1'b0;
    rd_addr    = pos[AW-1:0];
    case (state)
      bps_pkg::S_LOAD: begin
        in_stall = 1'b0;
        if (accept && in_last) begin
          state_next = short_arr ? bps_pkg::S_EMIT : bps_pkg::S_CHECK;
        end
      end
      bps_pkg::S_CHECK: begin
        rd_addr = AW'(pos - PW'(1));
        if (at_limit || out_of_range) begin
          state_next = bps_pkg::S_EMIT;
        end else begin
          state_next = bps_pkg::S_RD_MID;
        end
      end
      bps_pkg::S_RD_MID: begin
        rd_addr    = pos[AW-1:0];
        state_next = bps_pkg::S_RD_RGT;
      end
      bps_pkg::S_RD_RGT: begin
        rd_addr    = AW'(pos + PW'(1));
        state_next = bps_pkg::S_EVAL;
      end
      bps_pkg::S_EVAL: begin
        state_next = is_peak ? bps_pkg::S_EMIT : bps_pkg::S_CHECK;
      end
      bps_pkg::S_EMIT: begin
        res_load = res_free;
        if (res_free) begin
          state_next = bps_pkg::S_LOAD;
        end
      end
      default: begin
        state_next = bps_pkg::S_LOAD;
      end
    endcase
  end

  // count and probe counter are control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      probes <= '0;
    end else begin
      if (accept) begin
        count <= in_last ? '0 : n_next;
        if (in_last) begin
          probes <= '0;
        end
      end
      if (state == bps_pkg::S_CHECK && !at_limit) begin
        probes <= probes + LW'(1);
      end
    end
  end

  // search datapath
  always_ff @(posedge clk) begin
    case (state)
      bps_pkg::S_LOAD: begin
        if (accept && in_last) begin
          n          <= n_next;
          pos        <= $signed(PW'(n_next >> 1));
          step       <= n_next >> 1;
          res_index  <= '0;
          res_status <= bps_pkg::ST_SHORT;
        end
      end
      bps_pkg::S_CHECK: begin
        res_index <= '0;
        if (at_limit) begin
          res_status <= bps_pkg::ST_LIMIT;
        end else begin
          res_status <= bps_pkg::ST_RANGE;
        end
      end
      bps_pkg::S_RD_MID: begin
        lft <= $signed(rd_data);
      end
      bps_pkg::S_RD_RGT: begin
        mid <= $signed(rd_data);
      end
      bps_pkg::S_EVAL: begin
        if (is_peak) begin
          res_index  <= pos_wide[bps_pkg::INDEX_W-1:0];
          res_status <= bps_pkg::ST_FOUND;
        end else begin
          step <= step_next;
          pos  <= go_right ? (pos + $signed(PW'(step_next)))
                           : (pos - $signed(PW'(step_next)));
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/core/bitonic_peak_search.sv -----
// Top level of the bitonic peak search: store, sequencer and result register.
//
// Elements of a unimodal array arrive one per transaction on the element
// channel and are written to an internal store at one per cycle while
// loading; once MAX_ELEMENTS are held, further elements are dropped until
// the transaction flagged last_element, which ends the load and starts a
// binary peak search. The store has a single read port, so each probe runs
// through guard check (which also issues the left read), centre read, right
// read and compare. Once the last element is taken the element channel
// stalls for the search, which takes one more guard check when a guard
// rather than a peak ends it, and for the hand-off to the result register. A
// short array goes straight to the hand-off; a search run to the probe limit
// is the worst case. A unimodal array usually settles in about log2(n)
// probes. The hand-off lasts for as long as the output register still holds
// a stalled result. Exactly one result transaction follows each last
// element: the peak index with status 0, or index 0 with status 1 (fewer
// than three elements), 2 (probe left the range 1..count-2) or 3
// (PROBE_LIMIT probes used). The result sits in an output register, so a
// new array can be loaded while an earlier result is still waiting to be
// taken. No clearing pass is needed after reset.
module bitonic_peak_search #(
  parameter int MAX_ELEMENTS = bps_pkg::MAX_ELEMENTS_DEF,
  parameter int PROBE_LIMIT  = bps_pkg::PROBE_LIMIT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // element channel
  input  logic                          elem_valid,
  output logic                          elem_stall,
  input  logic signed [bps_pkg::ELEM_W-1:0] element_value,
  input  logic                          last_element,
  // result channel
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [bps_pkg::INDEX_W-1:0]   peak_index,
  output logic [bps_pkg::STATUS_W-1:0]  search_status
);

  localparam int AW = $clog2(MAX_ELEMENTS);

  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic [AW-1:0]                rd_addr;
  logic [bps_pkg::ELEM_W-1:0]   rd_data;
  logic                         res_free;
  logic                         res_load;
  logic [bps_pkg::INDEX_W-1:0]  res_index;
  bps_pkg::status_t             res_status;

  // Store is written only while loading and its read data is used only while
  // searching, so the sequencer's states keep the two apart.
  bps_store #(
    .DEPTH (MAX_ELEMENTS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (element_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bps_ctrl #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .PROBE_LIMIT  (PROBE_LIMIT),
    .AW           (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (elem_valid),
    .in_last    (last_element),
    .in_stall   (elem_stall),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .res_free   (res_free),
    .res_load   (res_load),
    .res_index  (res_index),
    .res_status (res_status)
  );

  // Output register: free when empty or being taken this cycle.
  assign res_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      peak_index    <= res_index;
      search_status <= res_status;
    end
  end

`ifndef SYNTHESIS
  // A fresh result never overwrites one still held by a stall.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!result_valid || !result_stall))
    else $error("result overwritten while stalled");

  // Any failed search reports index zero.
  a_fail_index_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && search_status != bps_pkg::ST_FOUND) |-> (peak_index == '0))
    else $error("nonzero index with failure status");

  // No element transaction is taken while a result is being handed off.
  a_no_load_on_emit: assert property (@(posedge clk) disable iff (rst)
    res_load |-> elem_stall)
    else $error("element taken during result hand-off");

  // Loading a result always makes it visible on the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    res_load |=> result_valid)
    else $error("loaded result not presented");
`endif

endmodule
